// ----- hw/rtl/pts_pkg.sv -----
// Shared types, character codes and decode helpers for the path token scanner.
`default_nettype none

package pts_pkg;

    // Most results one request can cause
    localparam int MAX_RESULTS = 3;

    // Token kinds
    localparam logic [2:0] KIND_LITERAL   = 3'd0;
    localparam logic [2:0] KIND_SLASH     = 3'd1;
    localparam logic [2:0] KIND_AT        = 3'd2;
    localparam logic [2:0] KIND_AMPERSAND = 3'd3;
    localparam logic [2:0] KIND_ASTERISK  = 3'd4;
    localparam logic [2:0] KIND_RANGE     = 3'd5;
    localparam logic [2:0] KIND_EOS       = 3'd6;

    // Error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_BAD_ESC   = 2'd1;
    localparam logic [1:0] ERR_CUT_ESC   = 2'd2;

    // Character codes
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_AT        = 8'h40;
    localparam logic [7:0] CH_AMPERSAND = 8'h26;
    localparam logic [7:0] CH_ASTERISK  = 8'h2A;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_X         = 8'h78;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_0         = 8'h30;
    localparam logic [7:0] CH_9         = 8'h39;
    localparam logic [7:0] CH_LA        = 8'h61;
    localparam logic [7:0] CH_LF        = 8'h66;
    localparam logic [7:0] CH_UA        = 8'h41;
    localparam logic [7:0] CH_UF        = 8'h46;
    localparam logic [7:0] HEX_TEN      = 8'd10;

    // Scanner modes
    typedef enum logic [2:0] {
        MODE_START = 3'd0,
        MODE_LIT   = 3'd1,
        MODE_RANGE = 3'd2,
        MODE_ESC   = 3'd3,
        MODE_HEX1  = 3'd4,
        MODE_HEX2  = 3'd5,
        MODE_DROP  = 3'd6
    } mode_t;

    typedef struct packed {
        logic [7:0] path_byte;
        logic       byte_present;
        logic       end_of_path;
    } item_t;

    typedef struct packed {
        logic [2:0] token_kind;
        logic [7:0] data_byte;
        logic       data_valid;
        logic       token_done;
        logic [1:0] error_code;
        logic       last_of_run;
    } result_t;

    // Results of one request plus how many of them are real
    typedef struct packed {
        result_t [MAX_RESULTS-1:0] res;
        logic [1:0]                count;
    } result_group_t;

    function automatic result_t make_result(
        input logic [2:0] kind,
        input logic [7:0] data,
        input logic       valid,
        input logic       done,
        input logic [1:0] err
    );
        result_t r;
        r.token_kind  = kind;
        r.data_byte   = data;
        r.data_valid  = valid;
        r.token_done  = done;
        r.error_code  = err;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    // Kind of a one-character token, literal when the byte is none of them
    function automatic logic [2:0] single_kind(input logic [7:0] c);
        logic [2:0] k;
        case (c)
            CH_SLASH:     k = KIND_SLASH;
            CH_AT:        k = KIND_AT;
            CH_AMPERSAND: k = KIND_AMPERSAND;
            CH_ASTERISK:  k = KIND_ASTERISK;
            default:      k = KIND_LITERAL;
        endcase
        return k;
    endfunction

    // Hex digit: bit 4 flags a digit, bits 3:0 carry its value
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        logic       ok;
        v  = 8'd0;
        ok = 1'b0;
        if (c >= CH_0 && c <= CH_9) begin
            v  = c - CH_0;
            ok = 1'b1;
        end else if (c >= CH_LA && c <= CH_LF) begin
            v  = c - CH_LA + HEX_TEN;
            ok = 1'b1;
        end else if (c >= CH_UA && c <= CH_UF) begin
            v  = c - CH_UA + HEX_TEN;
            ok = 1'b1;
        end
        return {ok, v[3:0]};
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/pts_decoder.sv -----
// Per-byte scan logic: mode update and the results one request causes.
`default_nettype none

module pts_decoder (
    input  pts_pkg::item_t         item,
    input  pts_pkg::mode_t         mode,
    input  logic [3:0]             nibble,
    output pts_pkg::result_group_t group,
    output pts_pkg::mode_t         next_mode,
    output logic [3:0]             next_nibble
);
    import pts_pkg::*;

    mode_t         m;
    result_group_t grp;
    logic [1:0]    n;
    logic          last_data;
    logic [7:0]    c;
    logic [2:0]    sk;
    logic [4:0]    hx;
    logic          is_bracket;

    always_comb
    begin
        grp         = '0;
        n           = 2'd0;
        last_data   = 1'b0;
        next_nibble = nibble;
        c           = item.path_byte;
        sk          = single_kind(c);
        hx          = hex_value(c);
        is_bracket  = (c == CH_LBRACKET) || (c == CH_LBRACE);
        m           = (mode > MODE_DROP) ? MODE_START : mode;

        // Handle the byte
        if (item.byte_present)
        begin
            // Close an open literal on a special character or bracket
            if (m == MODE_LIT && (sk != KIND_LITERAL || is_bracket))
            begin
                grp.res[n] = make_result(KIND_LITERAL, 8'd0, 1'b0, 1'b1, ERR_NONE);
                n = n + 2'd1;
                m = MODE_START;
            end
            case (m)
                MODE_START, MODE_LIT:
                begin
                    if (m == MODE_START && sk != KIND_LITERAL)
                    begin
                        grp.res[n] = make_result(sk, 8'd0, 1'b0, 1'b1, ERR_NONE);
                        n = n + 2'd1;
                    end else if (m == MODE_START && is_bracket)
                    begin
                        grp.res[n] = make_result(KIND_RANGE, c, 1'b1, 1'b0, ERR_NONE);
                        n = n + 2'd1;
                        last_data = 1'b1;
                        m = MODE_RANGE;
                    end else if (c == CH_BACKSLASH)
                    begin
                        m = MODE_ESC;
                    end else
                    begin
                        grp.res[n] = make_result(KIND_LITERAL, c, 1'b1, 1'b0, ERR_NONE);
                        n = n + 2'd1;
                        last_data = 1'b1;
                        m = MODE_LIT;
                    end
                end
                MODE_RANGE:
                begin
                    grp.res[n] = make_result(KIND_RANGE, c, 1'b1, 1'b0, ERR_NONE);
                    n = n + 2'd1;
                    last_data = 1'b1;
                end
                MODE_ESC:
                begin
                    if (c == CH_X)
                    begin
                        m = MODE_HEX1;
                    end else if (c == CH_BACKSLASH || is_bracket || sk != KIND_LITERAL)
                    begin
                        grp.res[n] = make_result(KIND_LITERAL, c, 1'b1, 1'b0, ERR_NONE);
                        n = n + 2'd1;
                        last_data = 1'b1;
                        m = MODE_LIT;
                    end else
                    begin
                        grp.res[n] = make_result(KIND_LITERAL, 8'd0, 1'b0, 1'b0, ERR_BAD_ESC);
                        n = n + 2'd1;
                        m = MODE_DROP;
                    end
                end
                MODE_HEX1:
                begin
                    if (!hx[4])
                    begin
                        grp.res[n] = make_result(KIND_LITERAL, 8'd0, 1'b0, 1'b0, ERR_BAD_ESC);
                        n = n + 2'd1;
                        m = MODE_DROP;
                    end else
                    begin
                        next_nibble = hx[3:0];
                        m = MODE_HEX2;
                    end
                end
                MODE_HEX2:
                begin
                    if (!hx[4])
                    begin
                        grp.res[n] = make_result(KIND_LITERAL, 8'd0, 1'b0, 1'b0, ERR_BAD_ESC);
                        n = n + 2'd1;
                        m = MODE_DROP;
                    end else
                    begin
                        grp.res[n] = make_result(KIND_LITERAL, {nibble, hx[3:0]},
                                                 1'b1, 1'b0, ERR_NONE);
                        n = n + 2'd1;
                        last_data = 1'b1;
                        m = MODE_LIT;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // Close the path
        if (item.end_of_path)
        begin
            case (m)
                MODE_LIT, MODE_RANGE:
                begin
                    if (last_data && n != 2'd0)
                    begin
                        grp.res[n - 2'd1].token_done = 1'b1;
                    end else
                    begin
                        grp.res[n] = make_result((m == MODE_LIT) ? KIND_LITERAL : KIND_RANGE,
                                                 8'd0, 1'b0, 1'b1, ERR_NONE);
                        n = n + 2'd1;
                    end
                    grp.res[n] = make_result(KIND_EOS, 8'd0, 1'b0, 1'b1, ERR_NONE);
                    n = n + 2'd1;
                end
                MODE_ESC:
                begin
                    grp.res[n] = make_result(KIND_LITERAL, 8'd0, 1'b0, 1'b0, ERR_CUT_ESC);
                    n = n + 2'd1;
                end
                MODE_HEX1, MODE_HEX2:
                begin
                    grp.res[n] = make_result(KIND_LITERAL, 8'd0, 1'b0, 1'b0, ERR_BAD_ESC);
                    n = n + 2'd1;
                end
                MODE_DROP:
                begin
                end
                default:
                begin
                    grp.res[n] = make_result(KIND_EOS, 8'd0, 1'b0, 1'b1, ERR_NONE);
                    n = n + 2'd1;
                end
            endcase
            m = MODE_START;
            next_nibble = 4'd0;
        end

        // Mark the final result of this request
        if (n != 2'd0)
        begin
            grp.res[n - 2'd1].last_of_run = 1'b1;
        end
        grp.count = n;
        group     = grp;
        next_mode = m;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/pts_result_buf.sv -----
// Result register: holds the results of one request and hands them out in order.
`default_nettype none

module pts_result_buf (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  pts_pkg::result_group_t group,
    output logic                   free,
    output logic                   result_valid,
    input  logic                   result_ready,
    output pts_pkg::result_t       result
);
    import pts_pkg::*;

    result_t [MAX_RESULTS-1:0] res_reg;
    logic [1:0]                count_reg;
    logic [1:0]                rd_reg;
    logic [1:0]                rd_next;
    logic                      pop;

    assign result_valid = (rd_reg != count_reg);
    assign result       = res_reg[rd_reg];
    assign pop          = result_valid && result_ready;
    assign rd_next      = rd_reg + 2'd1;

    // Free once empty or while the last result leaves
    assign free = !result_valid || (pop && rd_next == count_reg);

    // Advance the read pointer, load a new group when free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            rd_reg    <= 2'd0;
        end else if (load)
        begin
            count_reg <= group.count;
            rd_reg    <= 2'd0;
        end else if (pop)
        begin
            rd_reg    <= rd_next;
        end
    end

    // Hold the payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= group.res;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/path_token_scanner.sv -----
// Path token scanner top level: input register, scan logic and result register.
//
// Usage:
//   item_valid / item_ready / item carry one request: a path byte with its
//   present flag and an end-of-path mark. result_valid / result_ready / result
//   carry token results: kind, content byte, done flag, error code and a flag
//   on the last result a request causes.
//   A request accepted into the input register is scanned from there, and its
//   results are loaded into the result register once that register is free;
//   the first result is then offered from the result register.
//   One request enters per cycle while each causes at most one result and the
//   receiver is ready; a request causing several results holds the result
//   register, and so the input, until its last result leaves, since results
//   leave one per cycle while the receiver is ready.
//   Requests causing no result pass through without offering anything.
//   When the receiver stalls, the pending results hold and item_ready drops
//   while the input register holds a request.
//   Reset clears the scanner to token start, the high hex nibble to zero and
//   empties both registers.
`default_nettype none

module path_token_scanner (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  pts_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output pts_pkg::result_t result
);
    import pts_pkg::*;

    item_t         item_reg;
    logic          item_valid_reg;
    mode_t         mode_reg;
    mode_t         mode_next;
    logic [3:0]    nibble_reg;
    logic [3:0]    nibble_next;
    result_group_t group;
    logic          buf_free;
    logic          advance;
    logic          accept;

    assign advance    = item_valid_reg && buf_free;
    assign item_ready = !item_valid_reg || buf_free;
    assign accept     = item_valid && item_ready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end else if (accept)
        begin
            item_valid_reg <= 1'b1;
        end else if (advance)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
    end

    // Scan state advances with each request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_START;
            nibble_reg <= 4'd0;
        end else if (advance)
        begin
            mode_reg   <= mode_next;
            nibble_reg <= nibble_next;
        end
    end

    pts_decoder u_decoder (
        .item        (item_reg),
        .mode        (mode_reg),
        .nibble      (nibble_reg),
        .group       (group),
        .next_mode   (mode_next),
        .next_nibble (nibble_next)
    );

    pts_result_buf u_result_buf (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance),
        .group        (group),
        .free         (buf_free),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/pts_checker.sv -----
// Port-level checks on the path token scanner, bound to the top level.
`default_nettype none

module pts_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             result_valid,
    input logic             result_ready,
    input pts_pkg::result_t result
);
    import pts_pkg::*;

    // A stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result))
        else $error("result changed while stalled");

    // Content bytes belong only to literal and range tokens
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.data_valid |->
            (result.token_kind == KIND_LITERAL || result.token_kind == KIND_RANGE))
        else $error("content byte on a one-character or end token");

    // An error ends the request and carries no content
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.error_code != ERR_NONE |->
            result.last_of_run && !result.data_valid && !result.token_done)
        else $error("malformed error result");

    // End of stream is complete and closes its request
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.token_kind == KIND_EOS |->
            result.token_done && result.last_of_run && result.error_code == ERR_NONE)
        else $error("malformed end-of-stream result");

endmodule

bind path_token_scanner pts_checker u_pts_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

`default_nettype wire

// ----- bench/tb_path_token_scanner.sv -----
// Self-checking testbench for the path token scanner, with a token predictor.
`timescale 1ns / 100ps

module tb_path_token_scanner;

    import pts_pkg::*;

    // Tracks scanner state, predicts the tokens of each request and checks results
    class token_scoreboard;
        result_t    expected_tokens[$];
        result_t    run_tokens[0:MAX_RESULTS-1];
        int         run_len;
        mode_t      scan_state;
        logic [3:0] hex_upper;
        int         mismatches;
        int         tokens_checked;

        function new();
            scan_state     = MODE_START;
            hex_upper      = 4'd0;
            mismatches     = 0;
            tokens_checked = 0;
            run_len        = 0;
        endfunction

        function logic [2:0] char_kind(input logic [7:0] c);
            if (c == CH_SLASH)
                return KIND_SLASH;
            if (c == CH_AT)
                return KIND_AT;
            if (c == CH_AMPERSAND)
                return KIND_AMPERSAND;
            if (c == CH_ASTERISK)
                return KIND_ASTERISK;
            return KIND_LITERAL;
        endfunction

        function bit is_bracket(input logic [7:0] c);
            return (c == CH_LBRACKET) || (c == CH_LBRACE);
        endfunction

        // Value of a hex digit, -1 when the byte is not one
        function int hex_nibble(input logic [7:0] c);
            if (c >= CH_0 && c <= CH_9)
                return int'(c) - int'(CH_0);
            if (c >= CH_LA && c <= CH_LF)
                return int'(c) - int'(CH_LA) + 10;
            if (c >= CH_UA && c <= CH_UF)
                return int'(c) - int'(CH_UA) + 10;
            return -1;
        endfunction

        function void add_token(input logic [2:0] kind, input logic [7:0] data,
                                input logic valid, input logic done,
                                input logic [1:0] err);
            result_t r;
            r.token_kind  = kind;
            r.data_byte   = data;
            r.data_valid  = valid;
            r.token_done  = done;
            r.error_code  = err;
            r.last_of_run = 1'b0;
            run_tokens[run_len] = r;
            run_len++;
        endfunction

        // Advance the scanner by one accepted request and queue its tokens
        function void note_request(input item_t req);
            mode_t      m;
            logic [7:0] c;
            logic [2:0] k;
            int         hx;
            bit         ends_on_data;
            result_t    tail;
            int         i;
            c            = req.path_byte;
            m            = scan_state;
            k            = char_kind(c);
            hx           = hex_nibble(c);
            ends_on_data = 1'b0;
            run_len      = 0;

            if (req.byte_present) begin
                // close an open literal ahead of a special character or bracket
                if (m == MODE_LIT && (k != KIND_LITERAL || is_bracket(c))) begin
                    add_token(KIND_LITERAL, 8'd0, 1'b0, 1'b1, ERR_NONE);
                    m = MODE_START;
                end
                case (m)
                    MODE_START, MODE_LIT: begin
                        if (m == MODE_START && k != KIND_LITERAL) begin
                            add_token(k, 8'd0, 1'b0, 1'b1, ERR_NONE);
                        end else if (m == MODE_START && is_bracket(c)) begin
                            add_token(KIND_RANGE, c, 1'b1, 1'b0, ERR_NONE);
                            ends_on_data = 1'b1;
                            m = MODE_RANGE;
                        end else if (c == CH_BACKSLASH) begin
                            m = MODE_ESC;
                        end else begin
                            add_token(KIND_LITERAL, c, 1'b1, 1'b0, ERR_NONE);
                            ends_on_data = 1'b1;
                            m = MODE_LIT;
                        end
                    end
                    MODE_RANGE: begin
                        add_token(KIND_RANGE, c, 1'b1, 1'b0, ERR_NONE);
                        ends_on_data = 1'b1;
                    end
                    MODE_ESC: begin
                        if (c == CH_X) begin
                            m = MODE_HEX1;
                        end else if (c == CH_BACKSLASH || is_bracket(c) ||
                                     k != KIND_LITERAL) begin
                            add_token(KIND_LITERAL, c, 1'b1, 1'b0, ERR_NONE);
                            ends_on_data = 1'b1;
                            m = MODE_LIT;
                        end else begin
                            add_token(KIND_LITERAL, 8'd0, 1'b0, 1'b0, ERR_BAD_ESC);
                            m = MODE_DROP;
                        end
                    end
                    MODE_HEX1: begin
                        if (hx < 0) begin
                            add_token(KIND_LITERAL, 8'd0, 1'b0, 1'b0, ERR_BAD_ESC);
                            m = MODE_DROP;
                        end else begin
                            hex_upper = hx[3:0];
                            m = MODE_HEX2;
                        end
                    end
                    MODE_HEX2: begin
                        if (hx < 0) begin
                            add_token(KIND_LITERAL, 8'd0, 1'b0, 1'b0, ERR_BAD_ESC);
                            m = MODE_DROP;
                        end else begin
                            add_token(KIND_LITERAL, {hex_upper, hx[3:0]}, 1'b1, 1'b0,
                                      ERR_NONE);
                            ends_on_data = 1'b1;
                            m = MODE_LIT;
                        end
                    end
                    default: ;
                endcase
            end

            if (req.end_of_path) begin
                case (m)
                    MODE_LIT, MODE_RANGE: begin
                        // close the open token on its last byte, or with a token of its own
                        if (ends_on_data && run_len > 0) begin
                            tail = run_tokens[run_len-1];
                            tail.token_done = 1'b1;
                            run_tokens[run_len-1] = tail;
                        end else begin
                            add_token((m == MODE_LIT) ? KIND_LITERAL : KIND_RANGE,
                                      8'd0, 1'b0, 1'b1, ERR_NONE);
                        end
                        add_token(KIND_EOS, 8'd0, 1'b0, 1'b1, ERR_NONE);
                    end
                    MODE_ESC:
                        add_token(KIND_LITERAL, 8'd0, 1'b0, 1'b0, ERR_CUT_ESC);
                    MODE_HEX1, MODE_HEX2:
                        add_token(KIND_LITERAL, 8'd0, 1'b0, 1'b0, ERR_BAD_ESC);
                    MODE_DROP: ;
                    default:
                        add_token(KIND_EOS, 8'd0, 1'b0, 1'b1, ERR_NONE);
                endcase
                m = MODE_START;
                hex_upper = 4'd0;
            end

            scan_state = m;
            if (run_len > 0) begin
                tail = run_tokens[run_len-1];
                tail.last_of_run = 1'b1;
                run_tokens[run_len-1] = tail;
            end
            for (i = 0; i < run_len; i++)
                expected_tokens.push_back(run_tokens[i]);
        endfunction

        task report_mismatch(input string what);
            if (mismatches < 200)
                $display("[%0t] MISMATCH token %0d: %s", $time, tokens_checked, what);
            mismatches++;
        endtask

        task compare_field(input string name, input logic [7:0] got,
                           input logic [7:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %h want %h", name, got, want));
        endtask

        // Compare one accepted result with the oldest predicted token
        task check_token(input result_t got);
            result_t want;
            tokens_checked++;
            if (expected_tokens.size() == 0) begin
                report_mismatch($sformatf("unexpected token kind %0d data %h",
                                          got.token_kind, got.data_byte));
                return;
            end
            want = expected_tokens.pop_front();
            compare_field("token_kind", 8'(got.token_kind), 8'(want.token_kind));
            compare_field("data_byte", got.data_byte, want.data_byte);
            compare_field("data_valid", 8'(got.data_valid), 8'(want.data_valid));
            compare_field("token_done", 8'(got.token_done), 8'(want.token_done));
            compare_field("error_code", 8'(got.error_code), 8'(want.error_code));
            compare_field("last_of_run", 8'(got.last_of_run), 8'(want.last_of_run));
        endtask
    endclass

    logic    clk = 1'b0;
    logic    rst_n;
    logic    item_valid;
    logic    item_ready;
    item_t   item;
    logic    result_valid;
    logic    result_ready;
    result_t result;

    token_scoreboard sb;
    logic [7:0]      path_text[$];
    bit              steady = 1'b0;
    int              requests_sent = 0;
    int              paths_sent = 0;

    path_token_scanner dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #5 clk = ~clk;

    // Idle length: mostly none or short, now and then long
    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic bit is_reserved(input logic [7:0] c);
        return sb.char_kind(c) != KIND_LITERAL || sb.is_bracket(c) || c == CH_BACKSLASH;
    endfunction

    // Pick one of the escapable characters; limit 3 keeps to the one-character tokens
    function automatic logic [7:0] escapable_byte(input int limit);
        case ($urandom_range(0, limit))
            0:       return CH_SLASH;
            1:       return CH_AT;
            2:       return CH_AMPERSAND;
            3:       return CH_ASTERISK;
            4:       return CH_BACKSLASH;
            5:       return CH_LBRACKET;
            default: return CH_LBRACE;
        endcase
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (is_reserved(c));
        return c;
    endfunction

    function automatic logic [7:0] bad_escape_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (is_reserved(c) || c == CH_X);
        return c;
    endfunction

    function automatic logic [7:0] bad_hex_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (sb.hex_nibble(c) >= 0);
        return c;
    endfunction

    function automatic logic [7:0] hex_char();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10)
            return CH_0 + 8'(v);
        return ($urandom_range(0, 1) ? CH_LA : CH_UA) + 8'(v - 10);
    endfunction

    // Offer one request, after a random gap unless in steady mode, and hold it until accepted
    task automatic send_request(input logic [7:0] b, input logic present, input logic last);
        item_t req;
        int    gap;
        req.path_byte    = b;
        req.byte_present = present;
        req.end_of_path  = last;
        gap = steady ? 0 : gap_len();
        if (gap > 0) begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item       <= req;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        sb.note_request(req);
        requests_sent++;
    endtask

    task automatic load_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            path_text.push_back(s[i]);
    endtask

    // Send the queued path, ending on its last byte or with an end-only request
    task automatic send_path(input bit fold_end);
        int i;
        for (i = 0; i < path_text.size(); i++) begin
            if ($urandom_range(0, 39) == 0)
                send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_request(path_text[i], 1'b1, fold_end && i == path_text.size() - 1);
        end
        if (!fold_end || path_text.size() == 0)
            send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        path_text.delete();
        paths_sent++;
    endtask

    // Build a path mostly from well-formed pieces, with some noise and broken escapes
    task automatic build_random_path(output bit fold_end);
        int pieces;
        int p;
        int j;
        int roll;
        bit stop;
        pieces = $urandom_range(1, 6);
        stop   = 1'b0;
        for (p = 0; p < pieces && !stop; p++) begin
            roll = $urandom_range(0, 99);
            if (roll < 30) begin
                for (j = $urandom_range(1, 4); j > 0; j--)
                    path_text.push_back(plain_byte());
            end else if (roll < 45) begin
                path_text.push_back(escapable_byte(3));
            end else if (roll < 55) begin
                path_text.push_back(CH_BACKSLASH);
                path_text.push_back(escapable_byte(6));
            end else if (roll < 67) begin
                path_text.push_back(CH_BACKSLASH);
                path_text.push_back(CH_X);
                path_text.push_back(hex_char());
                path_text.push_back(hex_char());
            end else if (roll < 77) begin
                // open a range: everything after it is raw
                path_text.push_back($urandom_range(0, 1) ? CH_LBRACKET : CH_LBRACE);
                for (j = $urandom_range(0, 6); j > 0; j--)
                    path_text.push_back(8'($urandom_range(0, 255)));
                stop = 1'b1;
            end else if (roll < 85) begin
                path_text.push_back(8'($urandom_range(0, 255)));
            end else if (roll < 92) begin
                // malformed escape; the rest of the path is dropped
                path_text.push_back(CH_BACKSLASH);
                if ($urandom_range(0, 2) == 0) begin
                    path_text.push_back(bad_escape_byte());
                end else begin
                    path_text.push_back(CH_X);
                    if ($urandom_range(0, 1))
                        path_text.push_back(hex_char());
                    path_text.push_back(bad_hex_byte());
                end
            end else begin
                // escape cut off by the end of the path
                path_text.push_back(CH_BACKSLASH);
                roll = $urandom_range(0, 2);
                if (roll > 0)
                    path_text.push_back(CH_X);
                if (roll > 1)
                    path_text.push_back(hex_char());
                stop = 1'b1;
            end
        end
        fold_end = 1'($urandom_range(0, 1));
    endtask

    // Check every accepted result
    always @(posedge clk) begin
        if (rst_n && result_valid && result_ready)
            sb.check_token(result);
    end

    // Receiver: ready in runs, broken by random stalls
    initial begin
        int stall;
        int run;
        result_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever begin
            stall = steady ? 0 : gap_len();
            if (stall > 0) begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            run = $urandom_range(1, 12);
            repeat (run) @(posedge clk);
        end
    end

    initial begin
        bit fold;
        sb = new();
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        item       <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one-character tokens, alone and in a row
        load_text("/");
        send_path(1'b1);
        load_text("@&*");
        send_path(1'b1);
        // literal closed by a brace that opens a range
        load_text("a{");
        send_path(1'b1);
        // literal closed by a separate end request
        load_text("b");
        send_path(1'b0);
        // empty byte slot, then an empty path
        send_request(8'hA5, 1'b0, 1'b0);
        send_path(1'b0);
        // range with extreme raw bytes
        path_text.push_back(CH_LBRACKET);
        path_text.push_back(8'h00);
        path_text.push_back(8'hFF);
        send_path(1'b1);
        // escaped backslash, escaped bracket, hex byte
        load_text("\\\\\\[\\xF0");
        send_path(1'b1);
        // bad escape, then a byte that gets dropped
        load_text("\\qz");
        send_path(1'b0);
        // path ends after a backslash, then inside a hex escape
        load_text("\\");
        send_path(1'b0);
        load_text("\\xA");
        send_path(1'b1);

        while (requests_sent < 465) begin
            if ($urandom_range(0, 9) == 0)
                steady = !steady;
            build_random_path(fold);
            send_path(fold);
        end
        item_valid <= 1'b0;

        // drain, then allow for any stray late result
        while (sb.expected_tokens.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Scanned %0d paths in %0d requests; %0d tokens checked, %0d mismatches.",
                 paths_sent, requests_sent, sb.tokens_checked, sb.mismatches);
        if (sb.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Hang guard
    initial begin
        #5000000;
        $display("Timeout: %0d tokens still outstanding", sb.expected_tokens.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/pts_pkg.sv
hw/rtl/pts_decoder.sv
hw/rtl/pts_result_buf.sv
hw/rtl/path_token_scanner.sv
hw/rtl/pts_checker.sv
bench/tb_path_token_scanner.sv
